[rtl/srr_pkg.sv]
// ----------------------------------------------------------------------------
// srr_pkg
// Shared types, codes and helpers of the stereo reprojection residual core.
// ----------------------------------------------------------------------------
package srr_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int ROT_FRAC  = 30;
    localparam int ACC_W     = 50;
    localparam int DIV_W     = 2 * FRAC_BITS + 1;
    localparam int CNT_W     = $clog2(DIV_W + 1);

    localparam logic signed [ACC_W-1:0] WMAX =
        ACC_W'((64'sd1 <<< (WORD_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] WMIN = -WMAX - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ROT_ONE = ACC_W'(64'sd1 <<< ROT_FRAC);

    // input commands
    localparam logic [1:0] CMD_EVAL = 2'd0;
    localparam logic [1:0] CMD_POSE = 2'd1;
    localparam logic [1:0] CMD_EXTR = 2'd2;
    localparam logic [1:0] CMD_WROW = 2'd3;

    // result status
    localparam logic [1:0] RS_OK         = 2'd0;
    localparam logic [1:0] RS_ZERO_DEPTH = 2'd1;
    localparam logic [1:0] RS_SAT        = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_FOCAL_X  = 3'd0;
    localparam logic [2:0] CFG_FOCAL_Y  = 3'd1;
    localparam logic [2:0] CFG_CENTER_X = 3'd2;
    localparam logic [2:0] CFG_CENTER_Y = 3'd3;
    localparam logic [2:0] CFG_BASELINE = 3'd4;

    typedef enum logic [4:0] {
        DP_NOP, DP_POS, DP_OFF, DP_WROW, DP_QPROD_B, DP_QPROD_C, DP_QMAT_B,
        DP_QMAT_C, DP_DIFF, DP_ROTB, DP_ROTC, DP_DIVGO, DP_INVZ, DP_XN, DP_YN,
        DP_BT, DP_PX, DP_PY, DP_RES, DP_WHT, DP_ZRES, DP_PUBLISH
    } dp_op_t;

    typedef enum logic [2:0] {
        PG_POSE, PG_EXTR, PG_WROW, PG_EV1, PG_EV2
    } prog_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RUN, ST_ZCHK, ST_DIVGO, ST_DIVPAD, ST_DIVWAIT, ST_PUB
    } state_t;

    typedef struct packed {
        logic       capture;
        dp_op_t     op;
        logic [3:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic z_zero;
        logic div_busy;
        logic out_free;
    } dp_stat_t;

    typedef struct packed {
        dp_op_t     op;
        logic [3:0] idx;
        logic       last;
    } uop_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] val;
        logic                        ovf;
    } sat_t;

    typedef struct packed {
        logic [1:0] row;
        logic [1:0] col;
    } rc_t;

    function automatic sat_t sat_word(input logic signed [ACC_W-1:0] v);
        sat_t r;
        if (v > WMAX) begin
            r.val = WMAX[WORD_BITS-1:0];
            r.ovf = 1'b1;
        end else if (v < WMIN) begin
            r.val = WMIN[WORD_BITS-1:0];
            r.ovf = 1'b1;
        end else begin
            r.val = v[WORD_BITS-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    function automatic logic signed [ACC_W-1:0] ext(input logic signed [WORD_BITS-1:0] x);
        return ACC_W'(x);
    endfunction

    function automatic logic [WORD_BITS-1:0] mag_of(input logic signed [WORD_BITS-1:0] x);
        return x[WORD_BITS-1] ? WORD_BITS'(-x) : WORD_BITS'(x);
    endfunction

    // row and column of a 3x3 entry, row major
    function automatic rc_t split3(input logic [3:0] k);
        rc_t r;
        case (k)
            4'd0:    r = '{row: 2'd0, col: 2'd0};
            4'd1:    r = '{row: 2'd0, col: 2'd1};
            4'd2:    r = '{row: 2'd0, col: 2'd2};
            4'd3:    r = '{row: 2'd1, col: 2'd0};
            4'd4:    r = '{row: 2'd1, col: 2'd1};
            4'd5:    r = '{row: 2'd1, col: 2'd2};
            4'd6:    r = '{row: 2'd2, col: 2'd0};
            4'd7:    r = '{row: 2'd2, col: 2'd1};
            4'd8:    r = '{row: 2'd2, col: 2'd2};
            default: r = '{row: 2'd0, col: 2'd0};
        endcase
        return r;
    endfunction

    // micro-programs run by the controller, one datapath op per cycle
    function automatic uop_t prog_entry(input prog_t p, input logic [4:0] s);
        uop_t u;
        u.op   = DP_NOP;
        u.idx  = 4'd0;
        u.last = 1'b0;
        case (p)
            PG_POSE, PG_EXTR:
            begin
                if (s == 5'd0) begin
                    u.op = (p == PG_POSE) ? DP_POS : DP_OFF;
                end else if (s <= 5'd9) begin
                    u.op  = (p == PG_POSE) ? DP_QPROD_B : DP_QPROD_C;
                    u.idx = 4'(s - 5'd1);
                end else begin
                    u.op   = (p == PG_POSE) ? DP_QMAT_B : DP_QMAT_C;
                    u.idx  = 4'(s - 5'd10);
                    u.last = (s == 5'd18);
                end
            end
            PG_WROW:
            begin
                u.op   = DP_WROW;
                u.last = 1'b1;
            end
            PG_EV1:
            begin
                if (s <= 5'd2) begin
                    u.op  = DP_DIFF;
                    u.idx = 4'(s);
                end else if (s >= 5'd4 && s <= 5'd12) begin
                    u.op  = DP_ROTB;
                    u.idx = 4'(s - 5'd4);
                end else if (s >= 5'd14 && s <= 5'd22) begin
                    u.op  = DP_ROTC;
                    u.idx = 4'(s - 5'd14);
                end else begin
                    u.last = (s == 5'd23);
                end
            end
            PG_EV2:
            begin
                case (s)
                    5'd0: u.op = DP_INVZ;
                    5'd1: u.op = DP_NOP;
                    5'd2: u.op = DP_XN;
                    5'd3: u.op = DP_YN;
                    5'd4: u.op = DP_BT;
                    5'd5: u.op = DP_PX;
                    5'd6: u.op = DP_PY;
                    5'd7: u.op = DP_RES;
                    5'd8: u.op = DP_NOP;
                    default:
                    begin
                        u.op   = DP_WHT;
                        u.idx  = 4'(s - 5'd9);
                        u.last = (s == 5'd17);
                    end
                endcase
            end
            default: u.last = 1'b1;
        endcase
        return u;
    endfunction

endpackage

[rtl/srr_divider.sv]
// ----------------------------------------------------------------------------
// srr_divider
// Restoring divider for the depth reciprocal, one quotient bit per cycle:
// quotient = (2^(2*FRAC_BITS) + mag/2) / mag.
// ----------------------------------------------------------------------------
module srr_divider import srr_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [WORD_BITS-1:0] mag,
    output logic                 busy,
    output logic [DIV_W-1:0]     quotient
);

    logic [DIV_W-1:0]     num_reg;
    logic [DIV_W-1:0]     q_reg;
    logic [WORD_BITS-1:0] rem_reg;
    logic [WORD_BITS-1:0] den_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic [WORD_BITS:0]   cand;
    logic                 ge;

    always_comb
    begin
        cand = {rem_reg, num_reg[DIV_W-1]};
        ge   = (cand >= {1'b0, den_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(DIV_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            den_reg <= mag;
            num_reg <= (DIV_W'(1) << (2 * FRAC_BITS)) + DIV_W'(mag >> 1);
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? WORD_BITS'(cand - {1'b0, den_reg}) : cand[WORD_BITS-1:0];
            q_reg   <= {q_reg[DIV_W-2:0], ge};
            num_reg <= {num_reg[DIV_W-2:0], 1'b0};
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

[rtl/srr_controller.sv]
// ----------------------------------------------------------------------------
// srr_controller
// Sequencer: accepts items, steps the datapath through its micro-programs,
// waits on the divider and hands results to the output register.
// ----------------------------------------------------------------------------
module srr_controller import srr_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    input  dp_stat_t   stat,
    output dp_cmd_t    cmd
);

    state_t     state_reg, state_next;
    prog_t      prog_reg, prog_next;
    logic [4:0] step_reg, step_next;
    uop_t       uop;

    assign uop = prog_entry(prog_reg, step_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            prog_reg  <= PG_WROW;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            prog_reg  <= prog_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        prog_next  = prog_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                    case (command)
                        CMD_POSE: prog_next = PG_POSE;
                        CMD_EXTR: prog_next = PG_EXTR;
                        CMD_WROW: prog_next = PG_WROW;
                        default:  prog_next = PG_EV1;
                    endcase
                end
            end
            ST_RUN:
            begin
                step_next = step_reg + 5'd1;
                if (uop.last) begin
                    case (prog_reg)
                        PG_EV1:  state_next = ST_ZCHK;
                        PG_EV2:  state_next = ST_PUB;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ZCHK:    state_next = stat.z_zero ? ST_PUB : ST_DIVGO;
            ST_DIVGO:   state_next = ST_DIVPAD;
            ST_DIVPAD:  state_next = ST_DIVWAIT;
            ST_DIVWAIT:
            begin
                if (!stat.div_busy) begin
                    state_next = ST_RUN;
                    prog_next  = PG_EV2;
                    step_next  = '0;
                end
            end
            ST_PUB:
            begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.op      = DP_NOP;
        cmd.idx     = 4'd0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_RUN:
            begin
                cmd.op  = uop.op;
                cmd.idx = uop.idx;
            end
            ST_ZCHK:
            begin
                if (stat.z_zero) begin
                    cmd.op = DP_ZRES;
                end
            end
            ST_DIVGO:   cmd.op = DP_DIVGO;
            ST_PUB:
            begin
                if (stat.out_free) begin
                    cmd.op = DP_PUBLISH;
                end
            end
            default:    cmd.op = DP_NOP;
        endcase
    end

endmodule

[rtl/srr_datapath.sv]
// ----------------------------------------------------------------------------
// srr_datapath
// Stored pose, extrinsic and whitening state, one shared 32x32 multiplier
// with a product register, rounding and accumulation stage, and the divider.
// ----------------------------------------------------------------------------
module srr_datapath import srr_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dp_cmd_t                     cmd,
    output dp_stat_t                    stat,
    input  logic signed [WORD_BITS-1:0] operand_0,
    input  logic signed [WORD_BITS-1:0] operand_1,
    input  logic signed [WORD_BITS-1:0] operand_2,
    input  logic signed [WORD_BITS-1:0] operand_3,
    input  logic signed [WORD_BITS-1:0] operand_4,
    input  logic signed [WORD_BITS-1:0] operand_5,
    input  logic signed [WORD_BITS-1:0] operand_6,
    input  logic                        cfg_write,
    input  logic [2:0]                  cfg_index,
    input  logic [31:0]                 cfg_data,
    output logic signed [31:0]          residual_u,
    output logic signed [31:0]          residual_v,
    output logic signed [31:0]          residual_right_u,
    output logic [1:0]                  status,
    output logic                        out_valid,
    input  logic                        out_ready
);

    logic signed [WORD_BITS-1:0] op_reg [7];
    logic signed [WORD_BITS-1:0] pos_reg [3];
    logic signed [WORD_BITS-1:0] off_reg [3];
    logic signed [WORD_BITS-1:0] rb_reg [9];
    logic signed [WORD_BITS-1:0] rc_reg [9];
    logic signed [WORD_BITS-1:0] wh_reg [9];
    logic signed [35:0]          tmp_reg [9];
    logic signed [WORD_BITS-1:0] dv_reg [3];
    logic signed [WORD_BITS-1:0] av_reg [3];
    logic signed [WORD_BITS-1:0] pc_reg [3];
    logic signed [WORD_BITS-1:0] rr_reg [3];
    logic signed [WORD_BITS-1:0] res_reg [3];
    logic signed [WORD_BITS-1:0] invz_reg, xn_reg, yn_reg, px_reg, py_reg, bt_reg;
    logic [30:0]                 fx_reg, fy_reg;
    logic signed [31:0]          cx_reg, cy_reg, bf_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic                        sat_reg, zflag_reg;
    logic [2*WORD_BITS-1:0]      prod_reg;
    logic                        neg_reg;
    dp_op_t                      op2_reg;
    logic [3:0]                  idx2_reg;
    logic signed [31:0]          out_u_reg, out_v_reg, out_r_reg;
    logic [1:0]                  out_st_reg;
    logic                        out_valid_reg;

    logic signed [WORD_BITS-1:0] ma, mb;
    logic signed [WORD_BITS-1:0] qv [4];
    logic [1:0]                  qa, qb;
    rc_t                         rc1, rc2;
    logic [2*WORD_BITS-1:0]      rmag;
    logic signed [ACC_W-1:0]     rnd, sum, qsum;
    sat_t                        s_a, s_b, s_c, s_d;
    logic                        div_start, div_busy;
    logic [DIV_W-1:0]            quotient;
    logic signed [ACC_W-1:0]     qext;

    // ---------------- stage 1: operand select and multiply ----------------
    always_comb
    begin
        rc1 = split3(cmd.idx);
        if (cmd.op == DP_QPROD_B) begin
            qv[0] = op_reg[3]; qv[1] = op_reg[4]; qv[2] = op_reg[5]; qv[3] = op_reg[6];
        end else begin
            qv[0] = op_reg[0]; qv[1] = op_reg[1]; qv[2] = op_reg[2]; qv[3] = op_reg[3];
        end
        // xx yy zz xy xz yz wx wy wz
        case (cmd.idx)
            4'd0:    begin qa = 2'd0; qb = 2'd0; end
            4'd1:    begin qa = 2'd1; qb = 2'd1; end
            4'd2:    begin qa = 2'd2; qb = 2'd2; end
            4'd3:    begin qa = 2'd0; qb = 2'd1; end
            4'd4:    begin qa = 2'd0; qb = 2'd2; end
            4'd5:    begin qa = 2'd1; qb = 2'd2; end
            4'd6:    begin qa = 2'd3; qb = 2'd0; end
            4'd7:    begin qa = 2'd3; qb = 2'd1; end
            default: begin qa = 2'd3; qb = 2'd2; end
        endcase
        ma = '0;
        mb = '0;
        case (cmd.op)
            DP_QPROD_B, DP_QPROD_C:
            begin
                ma = qv[qa];
                mb = qv[qb];
            end
            DP_ROTB:
            begin
                ma = rb_reg[4'({rc1.col, 1'b0}) + 4'(rc1.col) + 4'(rc1.row)];
                mb = dv_reg[rc1.col];
            end
            DP_ROTC:
            begin
                ma = rc_reg[4'({rc1.col, 1'b0}) + 4'(rc1.col) + 4'(rc1.row)];
                mb = av_reg[rc1.col];
            end
            DP_XN: begin ma = pc_reg[0]; mb = invz_reg; end
            DP_YN: begin ma = pc_reg[1]; mb = invz_reg; end
            DP_BT: begin ma = bf_reg; mb = invz_reg; end
            DP_PX: begin ma = {1'b0, fx_reg}; mb = xn_reg; end
            DP_PY: begin ma = {1'b0, fy_reg}; mb = yn_reg; end
            DP_WHT:
            begin
                ma = wh_reg[cmd.idx];
                mb = rr_reg[rc1.col];
            end
            default: ma = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mag_of(ma) * mag_of(mb);
        neg_reg  <= ma[WORD_BITS-1] ^ mb[WORD_BITS-1];
        idx2_reg <= cmd.idx;
    end

    // ---------------- stage 2: round, accumulate, write back ----------------
    always_comb
    begin
        rc2 = split3(idx2_reg);
        case (op2_reg)
            DP_QPROD_B, DP_QPROD_C:
                rmag = (prod_reg + (64'd1 << (ROT_FRAC - 2))) >> (ROT_FRAC - 1);
            DP_ROTB, DP_ROTC:
                rmag = (prod_reg + (64'd1 << (ROT_FRAC - 1))) >> ROT_FRAC;
            default:
                rmag = (prod_reg + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        endcase
        rnd = neg_reg ? -$signed({1'b0, rmag[ACC_W-2:0]}) : $signed({1'b0, rmag[ACC_W-2:0]});
        sum = acc_reg + rnd;

        case (idx2_reg)
            4'd0:    qsum = ROT_ONE - (ACC_W'(tmp_reg[1]) + ACC_W'(tmp_reg[2]));
            4'd1:    qsum = ACC_W'(tmp_reg[3]) - ACC_W'(tmp_reg[8]);
            4'd2:    qsum = ACC_W'(tmp_reg[4]) + ACC_W'(tmp_reg[7]);
            4'd3:    qsum = ACC_W'(tmp_reg[3]) + ACC_W'(tmp_reg[8]);
            4'd4:    qsum = ROT_ONE - (ACC_W'(tmp_reg[0]) + ACC_W'(tmp_reg[2]));
            4'd5:    qsum = ACC_W'(tmp_reg[5]) - ACC_W'(tmp_reg[6]);
            4'd6:    qsum = ACC_W'(tmp_reg[4]) - ACC_W'(tmp_reg[7]);
            4'd7:    qsum = ACC_W'(tmp_reg[5]) + ACC_W'(tmp_reg[6]);
            default: qsum = ROT_ONE - (ACC_W'(tmp_reg[0]) + ACC_W'(tmp_reg[1]));
        endcase

        qext = $signed({{(ACC_W-DIV_W){1'b0}}, quotient});
        s_a = '0;
        s_b = '0;
        s_c = '0;
        s_d = '0;
        case (op2_reg)
            DP_QMAT_B, DP_QMAT_C: s_a = sat_word(qsum);
            DP_DIFF:
                s_a = sat_word(ext(op_reg[rc2.col]) - ext(pos_reg[rc2.col]));
            DP_ROTB:
            begin
                s_b = sat_word(sum);
                s_a = sat_word(ext(s_b.val) - ext(off_reg[rc2.row]));
            end
            DP_ROTC, DP_WHT: s_a = sat_word(sum);
            DP_INVZ: s_a = sat_word(pc_reg[2][WORD_BITS-1] ? -qext : qext);
            DP_XN, DP_YN, DP_BT: s_a = sat_word(rnd);
            DP_PX: s_a = sat_word(rnd + ext(cx_reg));
            DP_PY: s_a = sat_word(rnd + ext(cy_reg));
            DP_RES:
            begin
                s_a = sat_word(ext(px_reg) - ext(op_reg[3]));
                s_b = sat_word(ext(py_reg) - ext(op_reg[4]));
                s_c = sat_word(ext(px_reg) - ext(bt_reg));
                s_d = sat_word(ext(s_c.val) - ext(op_reg[5]));
            end
            default: s_a = '0;
        endcase
    end

    assign div_start = (op2_reg == DP_DIVGO);

    srr_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .mag      (mag_of(pc_reg[2])),
        .busy     (div_busy),
        .quotient (quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            op2_reg       <= DP_NOP;
            out_valid_reg <= 1'b0;
            sat_reg       <= 1'b0;
            zflag_reg     <= 1'b0;
            acc_reg       <= '0;
            fx_reg        <= '0;
            fy_reg        <= '0;
            cx_reg        <= '0;
            cy_reg        <= '0;
            bf_reg        <= '0;
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= '0;
                off_reg[i] <= '0;
            end
            for (int i = 0; i < 9; i++) begin
                rb_reg[i] <= (i % 4 == 0) ? WORD_BITS'(64'sd1 <<< ROT_FRAC) : '0;
                rc_reg[i] <= (i % 4 == 0) ? WORD_BITS'(64'sd1 <<< ROT_FRAC) : '0;
                wh_reg[i] <= (i % 4 == 0) ? WORD_BITS'(64'sd1 <<< FRAC_BITS) : '0;
            end
        end else begin
            op2_reg <= cmd.op;

            if (cfg_write) begin
                case (cfg_index)
                    CFG_FOCAL_X:  fx_reg <= cfg_data[30:0];
                    CFG_FOCAL_Y:  fy_reg <= cfg_data[30:0];
                    CFG_CENTER_X: cx_reg <= cfg_data;
                    CFG_CENTER_Y: cy_reg <= cfg_data;
                    CFG_BASELINE: bf_reg <= cfg_data;
                    default:      fx_reg <= fx_reg;
                endcase
            end

            if (cmd.capture) begin
                sat_reg   <= 1'b0;
                zflag_reg <= 1'b0;
                acc_reg   <= '0;
            end else if (s_a.ovf || s_b.ovf || s_c.ovf || s_d.ovf) begin
                sat_reg <= 1'b1;
            end

            if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end

            case (op2_reg)
                DP_POS:
                begin
                    pos_reg[0] <= op_reg[0];
                    pos_reg[1] <= op_reg[1];
                    pos_reg[2] <= op_reg[2];
                end
                DP_OFF:
                begin
                    off_reg[0] <= op_reg[4];
                    off_reg[1] <= op_reg[5];
                    off_reg[2] <= op_reg[6];
                end
                DP_WROW:
                begin
                    // drop rows outside 0..2
                    if (op_reg[0] == 32'sd0 || op_reg[0] == 32'sd1 || op_reg[0] == 32'sd2) begin
                        wh_reg[4'({op_reg[0][1:0], 1'b0}) + 4'(op_reg[0][1:0])]
                            <= op_reg[1];
                        wh_reg[4'({op_reg[0][1:0], 1'b0}) + 4'(op_reg[0][1:0]) + 4'd1]
                            <= op_reg[2];
                        wh_reg[4'({op_reg[0][1:0], 1'b0}) + 4'(op_reg[0][1:0]) + 4'd2]
                            <= op_reg[3];
                    end
                end
                DP_QMAT_B: rb_reg[idx2_reg] <= s_a.val;
                DP_QMAT_C: rc_reg[idx2_reg] <= s_a.val;
                DP_ROTB, DP_ROTC, DP_WHT:
                begin
                    acc_reg <= (rc2.col == 2'd2) ? '0 : sum;
                end
                DP_ZRES:   zflag_reg <= 1'b1;
                DP_PUBLISH:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:   acc_reg <= acc_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture) begin
            op_reg[0] <= operand_0;
            op_reg[1] <= operand_1;
            op_reg[2] <= operand_2;
            op_reg[3] <= operand_3;
            op_reg[4] <= operand_4;
            op_reg[5] <= operand_5;
            op_reg[6] <= operand_6;
        end
        case (op2_reg)
            DP_QPROD_B, DP_QPROD_C: tmp_reg[idx2_reg] <= rnd[35:0];
            DP_DIFF:  dv_reg[rc2.col] <= s_a.val;
            DP_ROTB:
            begin
                if (rc2.col == 2'd2) begin
                    av_reg[rc2.row] <= s_a.val;
                end
            end
            DP_ROTC:
            begin
                if (rc2.col == 2'd2) begin
                    pc_reg[rc2.row] <= s_a.val;
                end
            end
            DP_WHT:
            begin
                if (rc2.col == 2'd2) begin
                    res_reg[rc2.row] <= s_a.val;
                end
            end
            DP_INVZ: invz_reg <= s_a.val;
            DP_XN:   xn_reg <= s_a.val;
            DP_YN:   yn_reg <= s_a.val;
            DP_BT:   bt_reg <= s_a.val;
            DP_PX:   px_reg <= s_a.val;
            DP_PY:   py_reg <= s_a.val;
            DP_RES:
            begin
                rr_reg[0] <= s_a.val;
                rr_reg[1] <= s_b.val;
                rr_reg[2] <= s_d.val;
            end
            DP_ZRES:
            begin
                res_reg[0] <= '0;
                res_reg[1] <= '0;
                res_reg[2] <= '0;
            end
            DP_PUBLISH:
            begin
                out_u_reg  <= res_reg[0];
                out_v_reg  <= res_reg[1];
                out_r_reg  <= res_reg[2];
                out_st_reg <= zflag_reg ? RS_ZERO_DEPTH : (sat_reg ? RS_SAT : RS_OK);
            end
            default: bt_reg <= bt_reg;
        endcase
    end

    assign stat.z_zero   = (pc_reg[2] == '0);
    assign stat.div_busy = div_busy;
    assign stat.out_free = !out_valid_reg || out_ready;

    assign residual_u       = out_u_reg;
    assign residual_v       = out_v_reg;
    assign residual_right_u = out_r_reg;
    assign status           = out_st_reg;
    assign out_valid        = out_valid_reg;

    // a result beat is never overwritten before it is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (op2_reg == DP_PUBLISH) |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while waiting");

    // the divider never starts on a zero depth
    assert property (@(posedge clk) disable iff (!rst_n)
        (op2_reg == DP_DIVGO) |-> (pc_reg[2] != '0))
        else $error("divide started with zero depth");

    // the reciprocal is taken only once the divider has finished
    assert property (@(posedge clk) disable iff (!rst_n)
        (op2_reg == DP_INVZ) |-> !div_busy)
        else $error("reciprocal read while divider busy");

    // the accumulator is empty whenever a new item is captured
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> (acc_reg == '0))
        else $error("accumulator not cleared at capture");

endmodule

[rtl/stereo_reprojection_residual_core.sv]
// ----------------------------------------------------------------------------
// stereo_reprojection_residual_core
// Stereo reprojection residual: pose, extrinsic and whitening loads, and
// per-point whitened residual evaluation in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one command beat with seven
//   operands. Load beats (pose, extrinsic, whitening row) give no result;
//   an evaluate beat gives one result beat on the output channel
//   (out_valid/out_ready) with three whitened residuals and a status code.
//   Configuration (focal lengths, principal point, baseline times focal)
//   is written through cfg_write/cfg_index/cfg_data while the core is idle.
// Processing:
//   One item is processed at a time. An evaluate runs its products
//   through the one shared multiplier and the bit-serial depth
//   reciprocal divider; a zero depth skips the divider.
// Reset:
//   rst_n clears the configuration, the pose, the offset and sets the
//   rotations and the whitening matrix to identity.
// Stall:
//   A finished result waits in the output register; the core accepts and
//   works on the next item meanwhile and holds only before publishing its
//   own result while the previous beat has not been taken.
// ----------------------------------------------------------------------------
module stereo_reprojection_residual_core import srr_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic signed [31:0] operand_0,
    input  logic signed [31:0] operand_1,
    input  logic signed [31:0] operand_2,
    input  logic signed [31:0] operand_3,
    input  logic signed [31:0] operand_4,
    input  logic signed [31:0] operand_5,
    input  logic signed [31:0] operand_6,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] residual_u,
    output logic signed [31:0] residual_v,
    output logic signed [31:0] residual_right_u,
    output logic [1:0]         status,
    input  logic               cfg_write,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    srr_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .stat     (stat),
        .cmd      (cmd)
    );

    srr_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .operand_0        (operand_0),
        .operand_1        (operand_1),
        .operand_2        (operand_2),
        .operand_3        (operand_3),
        .operand_4        (operand_4),
        .operand_5        (operand_5),
        .operand_6        (operand_6),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .residual_u       (residual_u),
        .residual_v       (residual_v),
        .residual_right_u (residual_right_u),
        .status           (status),
        .out_valid        (out_valid),
        .out_ready        (out_ready)
    );

endmodule

[sim/stereo_reprojection_residual_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_reprojection_residual_core_tb
// Drives pose, extrinsic, whitening-row and evaluate beats through the core
// and compares each whitened residual beat against a bit-exact predictor
// built from 64-bit and 128-bit integer arithmetic.
// ----------------------------------------------------------------------------
module stereo_reprojection_residual_core_tb;
    import srr_pkg::*;

    typedef struct {
        logic [1:0]         cmd;
        logic signed [31:0] op [7];
    } point_beat_t;

    typedef struct {
        logic signed [31:0] ru;
        logic signed [31:0] rv;
        logic signed [31:0] rr;
        logic [1:0]         st;
    } residual_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         command;
    logic signed [31:0] operand_0, operand_1, operand_2, operand_3;
    logic signed [31:0] operand_4, operand_5, operand_6;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] residual_u, residual_v, residual_right_u;
    logic [1:0]         status;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [31:0]        cfg_data;

    stereo_reprojection_residual_core DUT (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .operand_0(operand_0), .operand_1(operand_1),
        .operand_2(operand_2), .operand_3(operand_3), .operand_4(operand_4),
        .operand_5(operand_5), .operand_6(operand_6), .out_valid(out_valid),
        .out_ready(out_ready), .residual_u(residual_u), .residual_v(residual_v),
        .residual_right_u(residual_right_u), .status(status),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state
    longint focal_x_q, focal_y_q, center_x_q, center_y_q, baseline_q;
    longint body_pos [3];
    longint body_rot [9];
    longint cam_rot [9];
    longint cam_off [3];
    longint white_m [9];
    bit     sat_flag;

    point_beat_t pending_beats [$];
    residual_t   expected_residuals [$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  recv_hold;
    int  mismatches;
    int  results_seen;
    int  beats_sent;
    int  eval_sent;
    int  zero_depth_seen;
    int  sat_seen_cnt;

    localparam longint W_HI = 64'sd2147483647;
    localparam longint W_LO = -64'sd2147483648;
    localparam longint MAG_CAP = 64'sd1 <<< 60;

    function automatic longint clamp_word(input longint v);
        if (v > W_HI)
        begin
            sat_flag = 1'b1;
            return W_HI;
        end
        if (v < W_LO)
        begin
            sat_flag = 1'b1;
            return W_LO;
        end
        return v;
    endfunction

    // round(a*b / 2^s), ties away from zero, magnitude capped
    function automatic longint mul_round(input longint a, input longint b, input int s);
        logic [127:0] ua, ub, p;
        bit           neg;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 128'(-a) : 128'(a);
        ub  = (b < 0) ? 128'(-b) : 128'(b);
        p   = ua * ub;
        if (s > 0)
            p = (p + (128'd1 << (s - 1))) >> s;
        if (p > 128'(MAG_CAP))
            p = 128'(MAG_CAP);
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    task automatic build_rotation(output longint m [9], input longint x, input longint y,
                                  input longint z, input longint w);
        longint one, xx, yy, zz, xy, xz, yz, wx, wy, wz;
        one = 64'sd1 <<< 30;
        xx = mul_round(x, x, 29); yy = mul_round(y, y, 29); zz = mul_round(z, z, 29);
        xy = mul_round(x, y, 29); xz = mul_round(x, z, 29); yz = mul_round(y, z, 29);
        wx = mul_round(w, x, 29); wy = mul_round(w, y, 29); wz = mul_round(w, z, 29);
        m[0] = clamp_word(one - (yy + zz));
        m[1] = clamp_word(xy - wz);
        m[2] = clamp_word(xz + wy);
        m[3] = clamp_word(xy + wz);
        m[4] = clamp_word(one - (xx + zz));
        m[5] = clamp_word(yz - wx);
        m[6] = clamp_word(xz - wy);
        m[7] = clamp_word(yz + wx);
        m[8] = clamp_word(one - (xx + yy));
    endtask

    task automatic rotate_back(output longint o [3], input longint m [9], input longint v [3]);
        for (int i = 0; i < 3; i++)
            o[i] = clamp_word(mul_round(m[i], v[0], 30) + mul_round(m[3 + i], v[1], 30)
                              + mul_round(m[6 + i], v[2], 30));
    endtask

    task automatic reset_predictor();
        focal_x_q = 0; focal_y_q = 0; center_x_q = 0; center_y_q = 0; baseline_q = 0;
        for (int i = 0; i < 9; i++)
        begin
            body_rot[i] = (i % 4 == 0) ? (64'sd1 <<< 30) : 0;
            cam_rot[i]  = (i % 4 == 0) ? (64'sd1 <<< 30) : 0;
            white_m[i]  = (i % 4 == 0) ? (64'sd1 <<< 16) : 0;
        end
        for (int i = 0; i < 3; i++)
        begin
            body_pos[i] = 0;
            cam_off[i]  = 0;
        end
    endtask

    // apply one beat to the predictor, queue a result for evaluates
    task automatic predict_beat(input point_beat_t b);
        longint op [7];
        longint d [3], a [3], pc [3], r [3];
        longint z, mag, invz, xn, yn, px, py, pr;
        logic [63:0] q;
        residual_t e;
        for (int i = 0; i < 7; i++)
            op[i] = longint'(b.op[i]);
        case (b.cmd)
            CMD_POSE:
            begin
                for (int i = 0; i < 3; i++)
                    body_pos[i] = op[i];
                build_rotation(body_rot, op[3], op[4], op[5], op[6]);
            end
            CMD_EXTR:
            begin
                build_rotation(cam_rot, op[0], op[1], op[2], op[3]);
                for (int i = 0; i < 3; i++)
                    cam_off[i] = op[4 + i];
            end
            CMD_WROW:
            begin
                if (op[0] >= 0 && op[0] <= 2)
                    for (int i = 0; i < 3; i++)
                        white_m[op[0] * 3 + i] = op[1 + i];
            end
            default:
            begin
                sat_flag = 1'b0;
                for (int i = 0; i < 3; i++)
                    d[i] = clamp_word(op[i] - body_pos[i]);
                rotate_back(a, body_rot, d);
                for (int i = 0; i < 3; i++)
                    a[i] = clamp_word(a[i] - cam_off[i]);
                rotate_back(pc, cam_rot, a);
                z = pc[2];
                if (z == 0)
                begin
                    e = '{ru: 0, rv: 0, rr: 0, st: RS_ZERO_DEPTH};
                end
                else
                begin
                    mag  = (z < 0) ? -z : z;
                    q    = ((64'd1 << 32) + 64'(mag) / 2) / 64'(mag);
                    invz = clamp_word(z < 0 ? -longint'(q) : longint'(q));
                    xn = clamp_word(mul_round(pc[0], invz, 16));
                    yn = clamp_word(mul_round(pc[1], invz, 16));
                    px = clamp_word(mul_round(focal_x_q, xn, 16) + center_x_q);
                    py = clamp_word(mul_round(focal_y_q, yn, 16) + center_y_q);
                    pr = clamp_word(px - clamp_word(mul_round(baseline_q, invz, 16)));
                    r[0] = clamp_word(px - op[3]);
                    r[1] = clamp_word(py - op[4]);
                    r[2] = clamp_word(pr - op[5]);
                    e.ru = 32'(clamp_word(mul_round(white_m[0], r[0], 16)
                        + mul_round(white_m[1], r[1], 16) + mul_round(white_m[2], r[2], 16)));
                    e.rv = 32'(clamp_word(mul_round(white_m[3], r[0], 16)
                        + mul_round(white_m[4], r[1], 16) + mul_round(white_m[5], r[2], 16)));
                    e.rr = 32'(clamp_word(mul_round(white_m[6], r[0], 16)
                        + mul_round(white_m[7], r[1], 16) + mul_round(white_m[8], r[2], 16)));
                    e.st = sat_flag ? RS_SAT : RS_OK;
                end
                expected_residuals.push_back(e);
            end
        endcase
    endtask

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // driver: hold the beat until taken, then advance
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_beat(pending_beats.pop_front());
                beats_sent <= beats_sent + 1;
            end
            if ((!in_valid || in_ready) && pending_beats.size() != 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid  <= 1'b1;
                command   <= pending_beats[0].cmd;
                operand_0 <= pending_beats[0].op[0];
                operand_1 <= pending_beats[0].op[1];
                operand_2 <= pending_beats[0].op[2];
                operand_3 <= pending_beats[0].op[3];
                operand_4 <= pending_beats[0].op[4];
                operand_5 <= pending_beats[0].op[5];
                operand_6 <= pending_beats[0].op[6];
            end
            else if (!in_valid || in_ready)
                in_valid <= 1'b0;
            if (recv_hold > 0)
            begin
                out_ready <= 1'b0;
                recv_hold <= recv_hold - 1;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        residual_t e;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
            if (status == RS_ZERO_DEPTH)
                zero_depth_seen <= zero_depth_seen + 1;
            if (status == RS_SAT)
                sat_seen_cnt <= sat_seen_cnt + 1;
            if (expected_residuals.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result beat %h %h %h st=%0d",
                             residual_u, residual_v, residual_right_u, status);
            end
            else
            begin
                e = expected_residuals.pop_front();
                if (e.ru !== residual_u || e.rv !== residual_v
                    || e.rr !== residual_right_u || e.st !== status)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch exp %h %h %h st=%0d got %h %h %h st=%0d",
                                 e.ru, e.rv, e.rr, e.st, residual_u, residual_v,
                                 residual_right_u, status);
                end
            end
        end
    end

    function automatic logic signed [31:0] rand_word();
        case ($urandom_range(5))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return $signed(32'($urandom_range(200000))) - 32'sd100000;
            default: return $signed(32'($urandom));
        endcase
    endfunction

    // Q2.30 quaternion component, mostly small enough to form near-unit sets
    function automatic logic signed [31:0] rand_quat();
        if ($urandom_range(9) == 0)
            return $signed($urandom);
        return $signed(32'($urandom_range(32'h40000000))) - 32'sh20000000;
    endfunction

    task automatic queue_beat(input logic [1:0] c, input logic signed [31:0] o0,
                              input logic signed [31:0] o1, input logic signed [31:0] o2,
                              input logic signed [31:0] o3, input logic signed [31:0] o4,
                              input logic signed [31:0] o5, input logic signed [31:0] o6);
        point_beat_t b;
        b.cmd = c;
        b.op  = '{o0, o1, o2, o3, o4, o5, o6};
        pending_beats.push_back(b);
        if (c == CMD_EVAL)
            eval_sent++;
    endtask

    task automatic queue_random(input int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 70)
                // plausible point in front of the camera, random observation
                queue_beat(CMD_EVAL,
                           $signed(32'($urandom_range(2000000))) - 32'sd1000000,
                           $signed(32'($urandom_range(2000000))) - 32'sd1000000,
                           ($urandom_range(3) == 0) ? rand_word()
                               : $signed(32'($urandom_range(3000000))) + 32'sd1000,
                           rand_word(), rand_word(), rand_word(), $signed($urandom));
            else if (k < 78)
                queue_beat(CMD_POSE, rand_word(), rand_word(), rand_word(), rand_quat(),
                           rand_quat(), rand_quat(), 32'sh40000000 - rand_quat() / 4);
            else if (k < 86)
                queue_beat(CMD_EXTR, rand_quat(), rand_quat(), rand_quat(),
                           32'sh40000000 - rand_quat() / 4, rand_word(), rand_word(),
                           rand_word());
            else if (k < 94)
                queue_beat(CMD_WROW, ($urandom_range(7) == 0) ? rand_word()
                               : $signed(32'($urandom_range(2))),
                           rand_word(), rand_word(), rand_word(), $signed($urandom),
                           $signed($urandom), $signed($urandom));
            else
                queue_beat(CMD_EVAL, rand_word(), rand_word(), rand_word(), rand_word(),
                           rand_word(), rand_word(), rand_word());
        end
    endtask

    task automatic wait_drained();
        while (pending_beats.size() != 0 || in_valid || expected_residuals.size() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_FOCAL_X:  focal_x_q  = longint'(val[30:0]);
            CFG_FOCAL_Y:  focal_y_q  = longint'(val[30:0]);
            CFG_CENTER_X: center_x_q = longint'($signed(val));
            CFG_CENTER_Y: center_y_q = longint'($signed(val));
            CFG_BASELINE: baseline_q = longint'($signed(val));
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_all(input logic [31:0] fx, input logic [31:0] fy,
                             input logic [31:0] cx, input logic [31:0] cy,
                             input logic [31:0] bf);
        write_reg(CFG_FOCAL_X, fx);
        write_reg(CFG_FOCAL_Y, fy);
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_BASELINE, bf);
    endtask

    initial
    begin
        rst_n = 1'b0; in_valid = 1'b0; out_ready = 1'b0; command = CMD_EVAL;
        operand_0 = 0; operand_1 = 0; operand_2 = 0; operand_3 = 0;
        operand_4 = 0; operand_5 = 0; operand_6 = 0;
        cfg_write = 1'b0; cfg_index = CFG_FOCAL_X; cfg_data = 0;
        mismatches = 0; results_seen = 0; beats_sent = 0; eval_sent = 0;
        zero_depth_seen = 0; sat_seen_cnt = 0; recv_hold = 0;
        send_idle_pct = 17; recv_idle_pct = 80;
        reset_predictor();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset state first, then extremes and every command
        queue_beat(CMD_EVAL, 32'sd65536, 32'sd131072, 32'sd0, 0, 0, 0, 0);
        queue_beat(CMD_EVAL, 32'sd65536, -32'sd65536, 32'sd196608, 32'sd1, 32'sd2, 32'sd3, 0);
        wait_drained();
        write_all(32'h0200_0000, 32'h01F0_0000, 32'h0140_0000, 32'h00F0_0000, 32'h0010_0000);
        queue_beat(CMD_EVAL, 32'sd65536, 32'sd65536, 32'sd65536 * 4, 0, 0, 0, 0);
        queue_beat(CMD_EVAL, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF,
                   32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        queue_beat(CMD_EVAL, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                   32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
        queue_beat(CMD_EVAL, 0, 0, 32'sd1, 0, 0, 0, 0);
        queue_beat(CMD_EVAL, 0, 0, -32'sd1, 0, 0, 0, 0);
        queue_beat(CMD_POSE, 32'sd65536, 0, 32'sd0, 0, 0, 0, 32'sh40000000);
        queue_beat(CMD_EVAL, 32'sd65536, 32'sd5, 0, 0, 0, 0, 0);
        queue_beat(CMD_POSE, 0, 0, 0, 32'sh2D413CCD, 0, 0, 32'sh2D413CCD);
        queue_beat(CMD_EXTR, 0, 32'sh2D413CCD, 0, 32'sh2D413CCD, 32'sd1000, -32'sd2000,
                   32'sh80000000);
        queue_beat(CMD_EVAL, 32'sd300000, -32'sd400000, 32'sd900000, 32'sd7, -32'sd7, 0, 0);
        queue_beat(CMD_POSE, 32'sh7FFFFFFF, 32'sh80000000, 0, 32'sh7FFFFFFF,
                   32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000);
        queue_beat(CMD_EVAL, 32'sd12345, 32'sd54321, 32'sd99999, 0, 0, 0, 0);
        queue_beat(CMD_WROW, 32'sd0, 32'sh7FFFFFFF, 32'sh80000000, 32'sd65536, -1, -1, -1);
        queue_beat(CMD_WROW, 32'sd2, 32'sd0, 32'sd32768, 32'sh80000000, 0, 0, 0);
        queue_beat(CMD_WROW, 32'sd3, 32'sd1, 32'sd1, 32'sd1, 0, 0, 0);
        queue_beat(CMD_WROW, -32'sd1, 32'sd1, 32'sd1, 32'sd1, 0, 0, 0);
        queue_beat(CMD_WROW, 32'sd1, 32'sd0, 32'sd65536, 32'sd0, 0, 0, 0);
        queue_beat(CMD_POSE, 0, 0, 0, 0, 0, 0, 32'sh40000000);
        queue_beat(CMD_EXTR, 0, 0, 0, 32'sh40000000, 0, 0, 0);
        queue_beat(CMD_EVAL, 32'sd100000, 32'sd200000, 32'sd300000, 32'sd10, 32'sd20,
                   32'sd30, 0);
        wait_drained();

        // phase one: sender light, receiver heavy
        write_all(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_random(180);
        wait_drained();
        write_all($urandom, $urandom, $urandom, $urandom, $urandom);
        queue_random(180);
        // long receiver hold-off while the sender keeps offering beats
        recv_hold = 400;
        wait_drained();

        // phase two: sender heavy, receiver light
        send_idle_pct = 80; recv_idle_pct = 17;
        write_all(32'h0100_0000, 32'h0100_0000, 32'h0, 32'h0, 32'h7FFF_FFFF);
        queue_random(180);
        wait_drained();
        write_all($urandom & 32'h03FF_FFFF, $urandom & 32'h03FF_FFFF,
                  $urandom, $urandom, $urandom);
        queue_random(180);
        wait_drained();

        // phase three: no idling
        send_idle_pct = 0; recv_idle_pct = 0;
        write_all(32'h01F4_0000, 32'h01F4_0000, 32'h0140_0000, 32'h00F0_0000,
                  32'h0200_0000);
        queue_random(180);
        wait_drained();
        write_all(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        queue_random(180);
        wait_drained();

        $display("covered %0d beats, %0d evaluates, %0d results checked",
                 beats_sent, eval_sent, results_seen);
        $display("depth-zero results %0d, saturated results %0d, mismatches %0d",
                 zero_depth_seen, sat_seen_cnt, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/srr_pkg.sv
rtl/srr_divider.sv
rtl/srr_controller.sv
rtl/srr_datapath.sv
rtl/stereo_reprojection_residual_core.sv
sim/stereo_reprojection_residual_core_tb.sv
